// File: rtl/core/symmetric_2x2_eigen_solver_macros.svh
// ---------------------------------------------------------------------------
// Symmetric 2x2 eigen solver assertion macros
// Shared concurrent assertion forms used by the checker.
// ---------------------------------------------------------------------------
`ifndef SYMMETRIC_2X2_EIGEN_SOLVER_MACROS_SVH
`define SYMMETRIC_2X2_EIGEN_SOLVER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define S2E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define S2E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define S2E_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/s2e_pkg.sv
// ---------------------------------------------------------------------------
// s2e_pkg
// Field widths shared by the eigen solver and its checker.
// ---------------------------------------------------------------------------
package s2e_pkg;

  localparam int IN_W  = 32;  // matrix entry width
  localparam int EIG_W = 35;  // eigenvalue width
  localparam int VEC_W = 16;  // eigenvector component width

  typedef logic signed [EIG_W-1:0] eig_t;
  typedef logic signed [VEC_W-1:0] vec_t;

endpackage

// File: rtl/core/s2e_isqrt.sv
// ---------------------------------------------------------------------------
// s2e_isqrt
// Pipelined floor square root, one root bit per stage, several lanes.
// ---------------------------------------------------------------------------
module s2e_isqrt #(
  parameter int RAD_W  = 68,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            vld_in,
  input  logic [LANES*RAD_W-1:0]          rad_in,
  input  logic [SIDE_W-1:0]               side_in,
  output logic                            vld_out,
  output logic [LANES*(RAD_W/2)-1:0]      root_out,
  output logic [SIDE_W-1:0]               side_out
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 3;

  logic              vld_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W][LANES];
  logic [REM_W-1:0]  rem_q  [ROOT_W][LANES];
  logic [ROOT_W-1:0] root_q [ROOT_W][LANES];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic              vld_c;
    logic [SIDE_W-1:0] side_c;

    if (g == 0) begin : g_first
      assign vld_c  = vld_in;
      assign side_c = side_in;
    end else begin : g_rest
      assign vld_c  = vld_q[g-1];
      assign side_c = side_q[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[g] <= side_c;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RAD_W-1:0]  rad_c;
      logic [REM_W-1:0]  rem_c;
      logic [ROOT_W-1:0] root_c;
      logic [REM_W-1:0]  rem_sh;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (g == 0) begin : g_src0
        assign rad_c  = rad_in[l*RAD_W +: RAD_W];
        assign rem_c  = '0;
        assign root_c = '0;
      end else begin : g_srcn
        assign rad_c  = rad_q[g-1][l];
        assign rem_c  = rem_q[g-1][l];
        assign root_c = root_q[g-1][l];
      end

      // bring down the next bit pair, try root*4+1
      assign rem_sh = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
      assign trial  = {1'b0, root_c, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[g][l]  <= {rad_c[RAD_W-3:0], 2'b00};
          rem_q[g][l]  <= ge ? (rem_sh - trial) : rem_sh;
          root_q[g][l] <= {root_c[ROOT_W-2:0], ge};
        end
      end

      if (g == ROOT_W - 1) begin : g_out
        assign root_out[l*ROOT_W +: ROOT_W] = root_q[g][l];
      end
    end
  end

  assign vld_out  = vld_q[ROOT_W-1];
  assign side_out = side_q[ROOT_W-1];

endmodule

// File: rtl/core/s2e_div_frac.sv
// ---------------------------------------------------------------------------
// s2e_div_frac
// Pipelined restoring division of two numerators by a shared denominator.
// Gives floor(num * 2^(QUO_W-1) / den) for num <= den, one bit per stage.
// ---------------------------------------------------------------------------
module s2e_div_frac #(
  parameter int DEN_W  = 68,
  parameter int QUO_W  = 29,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic [2*DEN_W-1:0]   num_in,
  input  logic [DEN_W-1:0]     den_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 vld_out,
  output logic [2*QUO_W-1:0]   quo_out,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int LANES = 2;

  logic              vld_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W][LANES];
  logic [QUO_W-1:0]  quo_q  [QUO_W][LANES];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic              vld_c;
    logic [SIDE_W-1:0] side_c;
    logic [DEN_W-1:0]  den_c;

    if (g == 0) begin : g_first
      assign vld_c  = vld_in;
      assign side_c = side_in;
      assign den_c  = den_in;
    end else begin : g_rest
      assign vld_c  = vld_q[g-1];
      assign side_c = side_q[g-1];
      assign den_c  = den_q[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[g] <= 1'b0;
      end else if (en) begin
        vld_q[g] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[g] <= side_c;
        den_q[g]  <= den_c;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0]   part;
      logic [DEN_W:0]   diff;
      logic [QUO_W-1:0] quo_c;
      logic             ge;

      if (g == 0) begin : g_src0
        assign part  = {1'b0, num_in[l*DEN_W +: DEN_W]};
        assign quo_c = '0;
      end else begin : g_srcn
        assign part  = {rem_q[g-1][l], 1'b0};
        assign quo_c = quo_q[g-1][l];
      end

      assign diff = part - {1'b0, den_c};
      assign ge   = (part >= {1'b0, den_c});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[g][l] <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
          quo_q[g][l] <= {quo_c[QUO_W-2:0], ge};
        end
      end

      if (g == QUO_W - 1) begin : g_out
        assign quo_out[l*QUO_W +: QUO_W] = quo_q[g][l];
      end
    end
  end

  assign vld_out  = vld_q[QUO_W-1];
  assign side_out = side_q[QUO_W-1];

endmodule

// File: rtl/core/symmetric_2x2_eigen_solver.sv
// ---------------------------------------------------------------------------
// symmetric_2x2_eigen_solver
// Closed-form eigenvalues and leading unit eigenvector of [[a,b],[b,c]].
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries a, b, c in signed Q15.16.
//   Output channel (result_valid / result_stall) returns one transaction per
//   input: eig_large >= eig_small in signed Q18.16, and the unit eigenvector
//   of eig_large as rot_cos / rot_sin with VEC_FRAC_BITS fraction bits,
//   truncated toward zero; a zero-length vector is reported as (1, 0).
//   Throughput: one transaction per cycle while the receiver does not stall,
//   no state between transactions. The pipeline runs through the 34-stage
//   root of the discriminant, the 2*VEC_FRAC_BITS+1 stage fraction divider
//   and the VEC_FRAC_BITS+1 stage root of the squared vector components.
//   Reset (rst, synchronous) clears every valid bit; payload is not reset.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and item_stall rises in the same cycle; bubbles keep moving
//   while the output register is empty.
// ---------------------------------------------------------------------------
module symmetric_2x2_eigen_solver #(
  parameter int VEC_FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic signed [31:0]         m_top_left,
  input  logic signed [31:0]         m_off_diag,
  input  logic signed [31:0]         m_bottom_right,
  output logic                       result_valid,
  input  logic                       result_stall,
  output s2e_pkg::eig_t              eig_large,
  output s2e_pkg::eig_t              eig_small,
  output s2e_pkg::vec_t              rot_cos,
  output s2e_pkg::vec_t              rot_sin
);

  localparam int EW     = s2e_pkg::EIG_W;
  localparam int QUO_W  = 2 * VEC_FRAC_BITS + 1;   // fraction quotient bits
  localparam int RAD2_W = 2 * VEC_FRAC_BITS + 2;   // even radicand width
  localparam int K_W    = RAD2_W / 2;              // root bits, VEC_FRAC_BITS+1
  localparam int VW     = (VEC_FRAC_BITS + 2 > s2e_pkg::VEC_W) ?
                          VEC_FRAC_BITS + 2 : s2e_pkg::VEC_W;
  localparam int N_W    = 68;                      // discriminant / norm width
  localparam int R_W    = N_W / 2;
  localparam int SIDE1_W = 33 + 32 + 1 + 64;
  localparam int SIDE2_W = 2 * EW + 2;

  // Pipeline advances whenever the output register is free or drained.
  logic adv;
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // Stage 1: capture inputs.
  logic               v1;
  logic signed [31:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= m_top_left;
      b1 <= m_off_diag;
      c1 <= m_bottom_right;
    end
  end

  // Stage 2: trace, |a-c|, |b|.
  logic signed [32:0] diff1;
  logic               v2, bneg2;
  logic signed [32:0] s2;
  logic signed [31:0] a2;
  logic [32:0]        ud2;
  logic [31:0]        ub2;

  assign diff1 = {a1[31], a1} - {c1[31], c1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2    <= {a1[31], a1} + {c1[31], c1};
      a2    <= a1;
      bneg2 <= b1[31];
      ud2   <= diff1[32] ? (~diff1 + 33'd1) : diff1;
      ub2   <= b1[31] ? (~b1 + 32'd1) : b1;
    end
  end

  // Stage 3: squares.
  logic               v3, bneg3;
  logic signed [32:0] s3;
  logic signed [31:0] a3;
  logic [65:0]        sq_d3;
  logic [63:0]        sq_b3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3    <= s2;
      a3    <= a2;
      bneg3 <= bneg2;
      sq_d3 <= 66'(ud2) * 66'(ud2);
      sq_b3 <= 64'(ub2) * 64'(ub2);
    end
  end

  // Stage 4: discriminant (a-c)^2 + 4b^2.
  logic               v4, bneg4;
  logic signed [32:0] s4;
  logic signed [31:0] a4;
  logic [63:0]        sq_b4;
  logic [N_W-1:0]     disc4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4    <= s3;
      a4    <= a3;
      bneg4 <= bneg3;
      sq_b4 <= sq_b3;
      disc4 <= N_W'(sq_d3) + {2'b00, sq_b3, 2'b00};
    end
  end

  // Floor root of the discriminant.
  logic               vr;
  logic [R_W-1:0]     rt;
  logic [SIDE1_W-1:0] side_r;
  logic signed [32:0] sr;
  logic signed [31:0] ar;
  logic               bnegr;
  logic [63:0]        sq_br;

  s2e_isqrt #(
    .RAD_W  (N_W),
    .LANES  (1),
    .SIDE_W (SIDE1_W)
  ) u_disc_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (v4),
    .rad_in   (disc4),
    .side_in  ({s4, a4, bneg4, sq_b4}),
    .vld_out  (vr),
    .root_out (rt),
    .side_out (side_r)
  );

  assign {sr, ar, bnegr, sq_br} = side_r;

  // Stage 5: eigenvalues floor((s +/- R)/2), e = w1 - a.
  logic signed [35:0] up5, dn5;
  logic signed [EW-1:0] w1c, ec;
  logic               v5, bneg5;
  logic signed [EW-1:0] w1_5, w2_5;
  logic [33:0]        e5;
  logic [63:0]        sq_b5;

  assign up5 = {{3{sr[32]}}, sr} + {2'b00, rt};
  assign dn5 = {{3{sr[32]}}, sr} - {2'b00, rt};
  assign w1c = up5[35:1];
  assign ec  = w1c - {{(EW-32){ar[31]}}, ar};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_5  <= w1c;
      w2_5  <= dn5[35:1];
      e5    <= ec[33:0];   // never negative
      bneg5 <= bnegr;
      sq_b5 <= sq_br;
    end
  end

  // Stage 6: e^2.
  logic               v6, bneg6;
  logic signed [EW-1:0] w1_6, w2_6;
  logic [63:0]        sq_b6;
  logic [N_W-1:0]     sq_e6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_6  <= w1_5;
      w2_6  <= w2_5;
      bneg6 <= bneg5;
      sq_b6 <= sq_b5;
      sq_e6 <= N_W'(e5) * N_W'(e5);
    end
  end

  // Stage 7: squared norm b^2 + e^2.
  logic               v7, bneg7, zero7;
  logic signed [EW-1:0] w1_7, w2_7;
  logic [N_W-1:0]     sq_b7, sq_e7, norm7;
  logic [N_W-1:0]     norm_c;

  assign norm_c = sq_e6 + N_W'(sq_b6);

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_7  <= w1_6;
      w2_7  <= w2_6;
      bneg7 <= bneg6;
      zero7 <= (norm_c == '0);
      sq_b7 <= N_W'(sq_b6);
      sq_e7 <= sq_e6;
      norm7 <= norm_c;
    end
  end

  // Squared unit components scaled by 2^(2F): x^2 * 2^(2F) / norm.
  logic               vd;
  logic [2*QUO_W-1:0] quo;
  logic [SIDE2_W-1:0] side_d;

  s2e_div_frac #(
    .DEN_W  (N_W),
    .QUO_W  (QUO_W),
    .SIDE_W (SIDE2_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (v7),
    .num_in   ({sq_e7, sq_b7}),
    .den_in   (norm7),
    .side_in  ({w1_7, w2_7, bneg7, zero7}),
    .vld_out  (vd),
    .quo_out  (quo),
    .side_out (side_d)
  );

  // Root of each squared component gives the truncated component.
  logic               vk;
  logic [2*K_W-1:0]   kk;
  logic [SIDE2_W-1:0] side_k;

  s2e_isqrt #(
    .RAD_W  (RAD2_W),
    .LANES  (2),
    .SIDE_W (SIDE2_W)
  ) u_vec_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vld_in   (vd),
    .rad_in   ({1'b0, quo[QUO_W +: QUO_W], 1'b0, quo[0 +: QUO_W]}),
    .side_in  (side_d),
    .vld_out  (vk),
    .root_out (kk),
    .side_out (side_k)
  );

  // Output register: sign of cos from b, (1,0) for a zero-length vector.
  logic signed [EW-1:0] w1k, w2k;
  logic                 bnegk, zerok;
  logic [VW-1:0]        kx, ky, cos_c, sin_c;

  assign {w1k, w2k, bnegk, zerok} = side_k;
  assign kx    = VW'(kk[0 +: K_W]);
  assign ky    = VW'(kk[K_W +: K_W]);
  assign cos_c = zerok ? (VW'(1) << VEC_FRAC_BITS) : (bnegk ? (~kx + VW'(1)) : kx);
  assign sin_c = zerok ? '0 : ky;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      eig_large <= w1k;
      eig_small <= w2k;
      rot_cos   <= cos_c[s2e_pkg::VEC_W-1:0];
      rot_sin   <= sin_c[s2e_pkg::VEC_W-1:0];
    end
  end

endmodule

// File: rtl/core/s2e_checker.sv
// ---------------------------------------------------------------------------
// s2e_checker
// Port-level checks for the eigen solver, bound to the top level.
// ---------------------------------------------------------------------------
`include "symmetric_2x2_eigen_solver_macros.svh"

module s2e_checker (
  input logic          clk,
  input logic          rst,
  input logic          item_stall,
  input logic          result_valid,
  input logic          result_stall,
  input s2e_pkg::eig_t eig_large,
  input s2e_pkg::eig_t eig_small
);

  // a waiting result stays offered
  `S2E_ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall, result_valid, "result dropped while stalled")

  // input side stalls exactly when a result is held back
  `S2E_ASSERT_NOW(a_stall, clk, rst, 1'b1, item_stall == (result_valid && result_stall), "stall coupling broken")

  // eigenvalue ordering
  `S2E_ASSERT_NOW(a_order, clk, rst, result_valid, eig_large >= eig_small, "eigenvalues out of order")

  // reset empties the output
  `S2E_ASSERT_ALWAYS_NEXT(a_reset, clk, rst, !result_valid, "result valid after reset")

endmodule

bind symmetric_2x2_eigen_solver s2e_checker u_s2e_checker (.*);

// File: bench/symmetric_2x2_eigen_solver_tb.sv
// ---------------------------------------------------------------------------
// symmetric_2x2_eigen_solver_tb
// Streams directed corner matrices and random Q15.16 matrices through the
// solver under random input gaps and output stalls, predicts eigenvalues and
// the leading unit eigenvector with exact integer math, and checks each
// result transaction in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module symmetric_2x2_eigen_solver_tb;

  localparam int VFB     = 14;
  localparam int LATENCY = 3 * VFB + 43;
  localparam int N_RAND  = 400;

  // one expected result transaction
  typedef struct packed {
    s2e_pkg::eig_t w1;
    s2e_pkg::eig_t w2;
    s2e_pkg::vec_t cs;
    s2e_pkg::vec_t sn;
  } eig_result_t;

  // floor integer square root of an unsigned 66-bit value
  function automatic logic [33:0] isqrt66(logic [65:0] n);
    logic [33:0] r;
    logic [33:0] t;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      t = r | (34'd1 << i);
      if ({34'd0, t} * {34'd0, t} <= {2'b0, n}) r = t;
    end
    return r;
  endfunction

  // floor(x * 2^VFB / sqrt(n)), with x^2 <= n, n > 0
  function automatic logic [15:0] unit_component(logic [35:0] x, logic [72:0] n);
    logic [127:0] target;
    logic [15:0]  k;
    logic [15:0]  cand;
    target = ({56'd0, x} * {56'd0, x}) << (2 * VFB);
    if ({56'd0, x} * {56'd0, x} == {55'd0, n}) return 16'd1 << VFB;
    k = '0;
    for (int i = VFB - 1; i >= 0; i--) begin
      cand = k | (16'd1 << i);
      if ({55'd0, n} * {112'd0, cand} * {112'd0, cand} <= target) k = cand;
    end
    return k;
  endfunction

  function automatic eig_result_t solve_matrix(logic signed [31:0] a,
                                               logic signed [31:0] b,
                                               logic signed [31:0] c);
    eig_result_t       res;
    logic signed [36:0] s, d, r, w1, w2, e;
    logic [65:0]       disc;
    logic [35:0]       ub, ue;
    logic [72:0]       nrm;
    logic [15:0]       cs;
    s    = 37'(a) + 37'(c);
    d    = 37'(a) - 37'(c);
    ub   = (b < 0) ? 36'(-37'(b)) : 36'(b);
    disc = 66'(d) * 66'(d) + 66'(4) * 66'(ub) * 66'(ub);
    r    = 37'(isqrt66(disc));
    w1   = (s + r) >>> 1;
    w2   = (s - r) >>> 1;
    e    = w1 - 37'(a);
    ue   = 36'(e);
    nrm  = 73'(ub) * 73'(ub) + 73'(ue) * 73'(ue);
    if (nrm == 0) begin
      res.cs = s2e_pkg::vec_t'(1 << VFB);
      res.sn = '0;
    end else begin
      cs     = unit_component(ub, nrm);
      res.cs = (b < 0) ? s2e_pkg::vec_t'(-cs) : s2e_pkg::vec_t'(cs);
      res.sn = s2e_pkg::vec_t'(unit_component(ue, nrm));
    end
    res.w1 = s2e_pkg::eig_t'(w1);
    res.w2 = s2e_pkg::eig_t'(w2);
    return res;
  endfunction

  // in-order scoreboard of predicted eigen results
  class eig_scoreboard;
    eig_result_t pending[$];
    int          mismatches;
    int          checked;

    function void note_matrix(logic signed [31:0] a, logic signed [31:0] b,
                              logic signed [31:0] c);
      pending.push_back(solve_matrix(a, b, c));
    endfunction

    function void check_result(eig_result_t got);
      eig_result_t exp;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp w1=%0d w2=%0d cos=%0d sin=%0d got w1=%0d w2=%0d cos=%0d sin=%0d",
                   exp.w1, exp.w2, exp.cs, exp.sn, got.w1, got.w2, got.cs, got.sn);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [31:0] m_top_left = '0, m_off_diag = '0, m_bottom_right = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  s2e_pkg::eig_t eig_large, eig_small;
  s2e_pkg::vec_t rot_cos, rot_sin;

  eig_scoreboard board = new();
  bit hold_off = 1'b0;   // long receiver hold-off request
  int n_sent = 0;

  always #2 clk = ~clk;

  symmetric_2x2_eigen_solver #(.VEC_FRAC_BITS(VFB)) i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .m_top_left(m_top_left), .m_off_diag(m_off_diag),
    .m_bottom_right(m_bottom_right),
    .result_valid(result_valid), .result_stall(result_stall),
    .eig_large(eig_large), .eig_small(eig_small),
    .rot_cos(rot_cos), .rot_sin(rot_sin)
  );

  // accept-side monitor: both channels sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.note_matrix(m_top_left, m_off_diag, m_bottom_right);
      if (result_valid && !result_stall)
        board.check_result('{eig_large, eig_small, rot_cos, rot_sin});
    end
  end

  // receiver stall pattern: random mode changes, quiet stretches, long hold-off
  initial begin
    int mode;
    mode = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: result_stall <= hold_off;
        1: result_stall <= hold_off | ($urandom_range(0, 3) == 0);
        2: result_stall <= hold_off | ($urandom_range(0, 1) == 0);
        default: result_stall <= hold_off | ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // long hold-off counted in its own process, once the stream is running
  initial begin
    wait (n_sent >= 150);
    hold_off = 1'b1;
    repeat (4 * LATENCY) @(posedge clk);
    hold_off = 1'b0;
  end

  // offer one matrix and hold it until accepted
  task automatic send_matrix(logic signed [31:0] a, logic signed [31:0] b,
                             logic signed [31:0] c);
    item_valid     <= 1'b1;
    m_top_left     <= a;
    m_off_diag     <= b;
    m_bottom_right <= c;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 512)) - 256);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic signed [31:0] a, b, c;
    int burst;
    int drain;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: zero matrix, diagonal cases, extremes, equal norms
    send_matrix(0, 0, 0);
    send_matrix(32'sh0001_0000, 0, 32'sh0002_0000);   // b = 0, a < c
    send_matrix(32'sh0003_0000, 0, 32'sh0001_0000);   // b = 0, a > c: zero norm
    send_matrix(32'sh0001_0000, 0, 32'sh0001_0000);   // scaled identity
    send_matrix(0, 32'sh0001_0000, 0);                // 45 degrees
    send_matrix(0, -32'sh0001_0000, 0);               // negative b
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_matrix(32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_matrix(32'h7FFF_FFFF, 0, 32'h8000_0000);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_matrix(1, 1, 0);
    send_matrix(-1, -1, 1);
    send_matrix(3, 2, -4);
    send_matrix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_matrix(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_matrix(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    idle_gap(1);

    // pause until the pipeline has drained completely
    while (board.pending.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RAND; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && i < N_RAND; j++, i++) begin
        a = rand_entry();
        b = rand_entry();
        c = ($urandom_range(0, 7) == 0) ? a : rand_entry();
        if ($urandom_range(0, 15) == 0) b = 0;
        send_matrix(a, b, c);
      end
      idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0);
    end
    idle_gap(1);

    drain = 0;
    while (board.pending.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY + 20) @(posedge clk);

    $display("covered %0d matrices: corner values, zero-norm and negative b cases,",
             n_sent);
    $display("random Q15.16 entries with input gaps, output stalls and a long hold-off");
    if (board.mismatches == 0 && board.pending.size() == 0 && board.checked == n_sent)
      $display("** symmetric_2x2_eigen_solver: PASSED **");
    else begin
      $display("mismatches %0d, still pending %0d", board.mismatches, board.pending.size());
      $display("** symmetric_2x2_eigen_solver: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("** symmetric_2x2_eigen_solver: FAILED **");
    $finish;
  end

endmodule

// File: symmetric_2x2_eigen_solver.f
+incdir+rtl/core
rtl/core/s2e_pkg.sv
rtl/core/s2e_isqrt.sv
rtl/core/s2e_div_frac.sv
rtl/core/symmetric_2x2_eigen_solver.sv
rtl/core/s2e_checker.sv
bench/symmetric_2x2_eigen_solver_tb.sv
